>>> rtl/core/tcsc_pkg.sv
// ----------------------------------------------------------------------------
// tcsc_pkg
// Types, constants and helpers shared by the two-channel sample combiner.
// ----------------------------------------------------------------------------
package tcsc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 17;
   localparam int COEF_SHIFT  = SAMPLE_BITS - 1;
   localparam int WIDE_BITS   = 40;
   localparam int CSR_IDX_BITS = 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;

   typedef enum logic [1:0] {
      OP_FIRST = 2'd0,
      OP_ROT   = 2'd1,
      OP_HALF  = 2'd2,
      OP_CONJ  = 2'd3
   } op_mode_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_OP_MODE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COS     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIN     = 2'd2;

   localparam op_mode_type OP_MODE_RESET = OP_HALF;
   localparam coef_type    COS_RESET     = COEF_BITS'(1 << COEF_SHIFT);
   localparam coef_type    SIN_RESET     = '0;

   localparam wide_type SAT_MAX = WIDE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam wide_type SAT_MIN = -SAT_MAX - WIDE_BITS'(1);

   function automatic sample_type sat_sample(input wide_type v);
      sample_type r;
      if (v > SAT_MAX) begin
         r = sample_type'(SAT_MAX[SAMPLE_BITS-1:0]);
      end else if (v < SAT_MIN) begin
         r = sample_type'(SAT_MIN[SAMPLE_BITS-1:0]);
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/tcsc_rotate.sv
// ----------------------------------------------------------------------------
// tcsc_rotate
// Two-stage phase rotation of channel one: products, then sum, shift, clip.
// ----------------------------------------------------------------------------
module tcsc_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tcsc_pkg::sample_type a_re,
   input  tcsc_pkg::sample_type a_im,
   input  tcsc_pkg::sample_type b_re,
   input  tcsc_pkg::sample_type b_im,
   input  tcsc_pkg::coef_type   cos_coef,
   input  tcsc_pkg::coef_type   sin_coef,
   output logic                out_valid,
   input  logic                out_ready,
   output tcsc_pkg::sample_type out_a_re,
   output tcsc_pkg::sample_type out_a_im,
   output tcsc_pkg::sample_type rot_re,
   output tcsc_pkg::sample_type rot_im
);
   import tcsc_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic s1_ready, s2_ready;

   logic signed [PROD_BITS-1:0] p_rc_ff, p_is_ff, p_ic_ff, p_rs_ff;
   logic signed [PROD_BITS-1:0] p_rc_in, p_is_in, p_ic_in, p_rs_in;
   sample_type s1_ar_ff, s1_ai_ff, s2_ar_ff, s2_ai_ff;
   sample_type rr_ff, ri_ff, rr_in, ri_in;
   logic signed [SUM_BITS-1:0] sum_re, sum_im;

   assign s2_ready = !s2_v_ff || out_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_v_in = s1_ready ? in_valid : s1_v_ff;
   assign s2_v_in = s2_ready ? s1_v_ff : s2_v_ff;

   assign p_rc_in = b_re * cos_coef;
   assign p_is_in = b_im * sin_coef;
   assign p_ic_in = b_im * cos_coef;
   assign p_rs_in = b_re * sin_coef;

   assign sum_re = SUM_BITS'(p_rc_ff) + SUM_BITS'(p_is_ff);
   assign sum_im = SUM_BITS'(p_ic_ff) - SUM_BITS'(p_rs_ff);
   assign rr_in  = sat_sample(WIDE_BITS'(sum_re >>> COEF_SHIFT));
   assign ri_in  = sat_sample(WIDE_BITS'(sum_im >>> COEF_SHIFT));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         p_rc_ff  <= p_rc_in;
         p_is_ff  <= p_is_in;
         p_ic_ff  <= p_ic_in;
         p_rs_ff  <= p_rs_in;
         s1_ar_ff <= a_re;
         s1_ai_ff <= a_im;
      end
      if (s2_ready) begin
         rr_ff    <= rr_in;
         ri_ff    <= ri_in;
         s2_ar_ff <= s1_ar_ff;
         s2_ai_ff <= s1_ai_ff;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_a_re  = s2_ar_ff;
   assign out_a_im  = s2_ai_ff;
   assign rot_re    = rr_ff;
   assign rot_im    = ri_ff;

endmodule

>>> rtl/core/two_channel_sample_combiner.sv
// ----------------------------------------------------------------------------
// two_channel_sample_combiner
// Rotates channel one by a programmed phase and combines it with channel zero.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one word per sample pair: a from channel zero, b from
//   channel one. rsp_ returns one word per request: a, rotated b, the
//   halved sum, or a times the conjugate of rotated b, clipped to 16 bits.
//   csr_ writes op_mode, cos_coef and sin_coef; write only while no word is
//   in flight.
//   Each word passes four register stages: coefficient products, rotate
//   sum and clip, combine products, combine sum and clip.
//   Throughput: one word per cycle while rsp_tready stays high.
//   Reset empties the pipeline and loads op_mode = halved sum, cos = 1.0,
//   sin = 0.
//   When rsp_tready is low the output word holds; empty stages still fill,
//   and req_tready falls only once all four stages hold a word.
// ----------------------------------------------------------------------------
module two_channel_sample_combiner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // a_re [15:0], a_im [31:16], b_re [47:32], b_im [63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_re [15:0], out_im [31:16]
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [tcsc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [tcsc_pkg::COEF_BITS-1:0]    csr_wdata
);
   import tcsc_pkg::*;

   localparam int MUL_BITS = 2 * SAMPLE_BITS;
   localparam int ACC_BITS = MUL_BITS + 1;
   localparam int HS_BITS  = SAMPLE_BITS + 1;

   op_mode_type op_mode_ff;
   coef_type    cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= OP_MODE_RESET;
         cos_ff     <= COS_RESET;
         sin_ff     <= SIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OP_MODE: op_mode_ff <= op_mode_type'(csr_wdata[1:0]);
            CSR_COS:     cos_ff     <= coef_type'(csr_wdata);
            CSR_SIN:     sin_ff     <= coef_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   logic       rot_valid, rot_ready;
   sample_type rot_ar, rot_ai, rot_re, rot_im;

   tcsc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .a_re      (sample_type'(req_tdata[15:0])),
      .a_im      (sample_type'(req_tdata[31:16])),
      .b_re      (sample_type'(req_tdata[47:32])),
      .b_im      (sample_type'(req_tdata[63:48])),
      .cos_coef  (cos_ff),
      .sin_coef  (sin_ff),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_a_re  (rot_ar),
      .out_a_im  (rot_ai),
      .rot_re    (rot_re),
      .rot_im    (rot_im)
   );

   logic s3_v_ff, s3_v_in, s4_v_ff, s4_v_in;
   logic s3_ready, s4_ready;

   assign s4_ready  = !s4_v_ff || rsp_tready;
   assign s3_ready  = !s3_v_ff || s4_ready;
   assign rot_ready = s3_ready;

   assign s3_v_in = s3_ready ? rot_valid : s3_v_ff;
   assign s4_v_in = s4_ready ? s3_v_ff : s4_v_ff;

   // stage 3: combine products and halved sum
   logic signed [MUL_BITS-1:0] m_rr_in, m_ii_in, m_ir_in, m_ri_in;
   logic signed [MUL_BITS-1:0] m_rr_ff, m_ii_ff, m_ir_ff, m_ri_ff;
   logic signed [HS_BITS-1:0]  hs_re, hs_im;
   sample_type half_re_in, half_im_in, half_re_ff, half_im_ff;
   sample_type s3_ar_ff, s3_ai_ff, s3_rr_ff, s3_ri_ff;

   assign m_rr_in = rot_ar * rot_re;
   assign m_ii_in = rot_ai * rot_im;
   assign m_ir_in = rot_ai * rot_re;
   assign m_ri_in = rot_ar * rot_im;

   // truncate toward zero: bias negative sums by one before the shift
   assign hs_re = HS_BITS'(rot_ar) + HS_BITS'(rot_re);
   assign hs_im = HS_BITS'(rot_ai) + HS_BITS'(rot_im);
   assign half_re_in = sample_type'((hs_re + HS_BITS'(hs_re[HS_BITS-1])) >>> 1);
   assign half_im_in = sample_type'((hs_im + HS_BITS'(hs_im[HS_BITS-1])) >>> 1);

   // stage 4: select and clip
   logic signed [ACC_BITS-1:0] acc_re, acc_im;
   sample_type out_re_in, out_im_in, out_re_ff, out_im_ff;

   assign acc_re = ACC_BITS'(m_rr_ff) + ACC_BITS'(m_ii_ff);
   assign acc_im = ACC_BITS'(m_ir_ff) - ACC_BITS'(m_ri_ff);

   always_comb begin
      case (op_mode_ff)
         OP_FIRST: begin
            out_re_in = s3_ar_ff;
            out_im_in = s3_ai_ff;
         end
         OP_ROT: begin
            out_re_in = s3_rr_ff;
            out_im_in = s3_ri_ff;
         end
         OP_HALF: begin
            out_re_in = half_re_ff;
            out_im_in = half_im_ff;
         end
         default: begin
            out_re_in = sat_sample(WIDE_BITS'(acc_re >>> COEF_SHIFT));
            out_im_in = sat_sample(WIDE_BITS'(acc_im >>> COEF_SHIFT));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         m_rr_ff    <= m_rr_in;
         m_ii_ff    <= m_ii_in;
         m_ir_ff    <= m_ir_in;
         m_ri_ff    <= m_ri_in;
         half_re_ff <= half_re_in;
         half_im_ff <= half_im_in;
         s3_ar_ff   <= rot_ar;
         s3_ai_ff   <= rot_ai;
         s3_rr_ff   <= rot_re;
         s3_ri_ff   <= rot_im;
      end
      if (s4_ready) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
      end
   end

   assign rsp_tvalid = s4_v_ff;
   assign rsp_tdata  = {out_im_ff, out_re_ff};

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-channel sample combiner.
// A table of hand-picked words runs first against the reset settings and a
// few fixed phases: mode extremes, half turn, quarter turn, coefficient
// patterns outside the unit range, product overflow and truncation of the
// halved sum. Random phases follow, each with a fresh mode and coefficient
// pair written while the pipe is empty. Every accepted word is predicted
// and the response stream is compared word by word, in order. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import tcsc_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int REQ_SIDE = 0;
   localparam int RSP_SIDE = 1;
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 128;

   localparam sample_type S_MAX = 16'sh7FFF;
   localparam sample_type S_MIN = 16'sh8000;
   localparam coef_type C_ONE  = 17'sd32768;
   localparam coef_type C_MONE = -17'sd32768;
   localparam coef_type C_TOP  = 17'sh0FFFF;
   localparam coef_type C_BOT  = 17'sh10000;

   typedef struct packed {
      sample_type im;
      sample_type re;
   } out_word_type;

   typedef struct packed {
      op_mode_type mode;
      coef_type    cos_c;
      coef_type    sin_c;
      bit          junk;
      sample_type  a_re;
      sample_type  a_im;
      sample_type  b_re;
      sample_type  b_im;
      bit          typed;
      sample_type  x_re;
      sample_type  x_im;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [COEF_BITS-1:0]    csr_wdata = '0;

   op_mode_type cur_mode = OP_MODE_RESET;
   coef_type    cur_cos  = COS_RESET;
   coef_type    cur_sin  = SIN_RESET;

   out_word_type due_q[$];
   int        bad_words = 0;
   int        calm_left[2] = '{0, 0};

   dir_row_type dir_tab [0:17] = '{
      '{OP_HALF, C_ONE, 17'sd0, 1'b0, 16'sd100, -16'sd100, 16'sd200, -16'sd200,
        1'b1, 16'sd150, -16'sd150},
      '{OP_HALF, C_ONE, 17'sd0, 1'b0, 16'sd1, -16'sd1, 16'sd0, 16'sd0,
        1'b1, 16'sd0, 16'sd0},
      '{OP_HALF, C_ONE, 17'sd0, 1'b0, S_MIN, S_MIN, S_MIN, S_MAX,
        1'b1, S_MIN, 16'sd0},
      '{OP_HALF, C_ONE, 17'sd0, 1'b0, S_MAX, S_MAX, S_MAX, S_MAX,
        1'b1, S_MAX, S_MAX},
      '{OP_FIRST, C_ONE, 17'sd0, 1'b0, S_MAX, S_MIN, 16'sd5, 16'sd5,
        1'b1, S_MAX, S_MIN},
      '{OP_FIRST, C_ONE, 17'sd0, 1'b1, -16'sd1, 16'sd0, S_MIN, S_MIN,
        1'b1, -16'sd1, 16'sd0},
      '{OP_ROT, C_ONE, 17'sd0, 1'b0, 16'sd0, 16'sd0, S_MIN, S_MAX,
        1'b1, S_MIN, S_MAX},
      '{OP_ROT, C_MONE, 17'sd0, 1'b0, 16'sd0, 16'sd0, S_MIN, S_MAX,
        1'b1, S_MAX, -16'sd32767},
      '{OP_ROT, 17'sd0, C_ONE, 1'b0, 16'sd7, 16'sd7, 16'sd1000, 16'sd2000,
        1'b1, 16'sd2000, -16'sd1000},
      '{OP_ROT, 17'sd0, C_ONE, 1'b0, 16'sd0, 16'sd0, S_MIN, S_MIN,
        1'b1, S_MIN, S_MAX},
      '{OP_ROT, C_TOP, C_BOT, 1'b0, 16'sd0, 16'sd0, S_MIN, S_MIN,
        1'b0, 16'sd0, 16'sd0},
      '{OP_ROT, C_BOT, C_TOP, 1'b0, 16'sd0, 16'sd0, S_MAX, S_MIN,
        1'b0, 16'sd0, 16'sd0},
      '{OP_CONJ, C_ONE, 17'sd0, 1'b0, S_MIN, S_MIN, S_MIN, S_MIN,
        1'b1, S_MAX, 16'sd0},
      '{OP_CONJ, C_ONE, 17'sd0, 1'b0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
        1'b1, 16'sd8192, 16'sd0},
      '{OP_CONJ, C_ONE, 17'sd0, 1'b0, 16'sd1, 16'sd0, -16'sd1, 16'sd0,
        1'b1, -16'sd1, 16'sd0},
      '{OP_CONJ, C_ONE, 17'sd0, 1'b0, S_MIN, S_MAX, S_MAX, S_MIN,
        1'b0, 16'sd0, 16'sd0},
      '{OP_HALF, C_ONE, C_ONE, 1'b0, S_MAX, S_MAX, S_MAX, S_MAX,
        1'b1, S_MAX, 16'sd16383},
      '{OP_HALF, C_ONE, C_ONE, 1'b0, -16'sd3, S_MIN, 16'sd0, -16'sd1,
        1'b1, -16'sd2, -16'sd16384}
   };

   two_channel_sample_combiner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic out_word_type rotate_combine(input sample_type ar, ai, br, bi);
      longint rr, ri, xr, xi;
      out_word_type w;
      rr = clip16((longint'(br) * longint'(cur_cos) + longint'(bi) * longint'(cur_sin))
                  >>> COEF_SHIFT);
      ri = clip16((longint'(bi) * longint'(cur_cos) - longint'(br) * longint'(cur_sin))
                  >>> COEF_SHIFT);
      case (cur_mode)
         OP_FIRST: begin
            xr = ar;
            xi = ai;
         end
         OP_ROT: begin
            xr = rr;
            xi = ri;
         end
         OP_HALF: begin
            xr = (longint'(ar) + rr) / 2;
            xi = (longint'(ai) + ri) / 2;
         end
         default: begin
            xr = (longint'(ar) * rr + longint'(ai) * ri) >>> COEF_SHIFT;
            xi = (longint'(ai) * rr - longint'(ar) * ri) >>> COEF_SHIFT;
         end
      endcase
      w.re = sample_type'(clip16(xr));
      w.im = sample_type'(clip16(xi));
      return w;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(input int side);
      int r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left[side] = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 15))
         0: return S_MAX;
         1: return S_MIN;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_type pick_coef();
      case ($urandom_range(0, 9))
         0: return C_TOP;
         1: return C_BOT;
         2: return C_ONE;
         3: return C_MONE;
         4: return 17'sd0;
         5, 6: return coef_type'($urandom);
         default: return coef_type'(int'($urandom_range(0, 65536)) - 32768);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_OP_MODE: cur_mode = op_mode_type'(val[1:0]);
         CSR_COS:     cur_cos  = val;
         CSR_SIN:     cur_sin  = val;
         default: ;
      endcase
   endtask

   // only with the pipe empty
   task automatic apply_setting(input op_mode_type m, input coef_type c, input coef_type s,
                                input bit junk);
      req_tvalid <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (junk) write_reg(CSR_SPARE, COEF_BITS'($urandom));
      write_reg(CSR_OP_MODE, {15'($urandom), m});
      write_reg(CSR_COS, c);
      write_reg(CSR_SIN, s);
      csr_we <= 1'b0;
   endtask

   task automatic send_pair(input sample_type ar, ai, br, bi, input bit typed,
                            input out_word_type fixed);
      int gap;
      gap = pick_gap(REQ_SIDE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bi, br, ai, ar};
      do @(posedge clock); while (!req_tready);
      due_q.push_back(typed ? fixed : rotate_combine(ar, ai, br, bi));
   endtask

   initial begin : stim
      dir_row_type row;
      out_word_type fx;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         if (row.mode != cur_mode || row.cos_c != cur_cos || row.sin_c != cur_sin
             || row.junk)
            apply_setting(row.mode, row.cos_c, row.sin_c, row.junk);
         fx.re = row.x_re;
         fx.im = row.x_im;
         send_pair(row.a_re, row.a_im, row.b_re, row.b_im, row.typed, fx);
      end
      for (int p = 0; p < PHASES; p++) begin
         apply_setting(op_mode_type'(p % 4), pick_coef(), pick_coef(),
                       $urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_WORDS; n++)
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (bad_words == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : rsp_side
      int hold;
      @(negedge reset);
      forever begin
         hold = pick_gap(RSP_SIDE);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      out_word_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (due_q.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected word: re=%0d im=%0d", got.re, got.im);
         end else begin
            want = due_q.pop_front();
            if (got.re !== want.re || got.im !== want.im) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("mismatch: want re=%0d im=%0d, got re=%0d im=%0d",
                           want.re, want.im, got.re, got.im);
            end
         end
      end
   end

   initial begin : watchdog
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
